// ===== rtl/rrqs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrqs_pkg
// Shared types and codes for the round-robin quantum scheduler.
// ----------------------------------------------------------------------------
package rrqs_pkg;

	localparam int ID_W    = 8;
	localparam int TIME_W  = 16;
	localparam int STAT_W  = 3;
	localparam int S_DATA_W = 24;   // proc_id, burst_time
	localparam int M_DATA_W = 40;   // served_id, units_run, time_left

	// request kinds carried in s_tuser
	localparam logic REQ_ENQUEUE = 1'b0;
	localparam logic REQ_STEP    = 1'b1;

	// result status codes carried in m_tuser
	localparam logic [STAT_W-1:0] STAT_ENQUEUED = 3'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
	localparam logic [STAT_W-1:0] STAT_SLICE    = 3'd2;
	localparam logic [STAT_W-1:0] STAT_DONE     = 3'd3;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;

	typedef struct packed {
		logic [TIME_W-1:0] remaining;
		logic [ID_W-1:0]   id;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

endpackage

// ===== rtl/round_robin_quantum_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_unit
// Round-robin time-slice scheduler over a ring of {id, remaining} entries.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: s_tuser selects enqueue or step, s_tdata
// carries the process id and burst time of an enqueue. Each request yields
// exactly one result transaction on the m_ stream, with the status code in
// m_tuser and served id, units run and time left in m_tdata.
// The quantum is written through cfg_valid/cfg_data, always ready, and takes
// effect at once; write it only while no request is in flight.
// The ring lives in a single-port-write, one-read synchronous memory of
// QUEUE_DEPTH entries. An enqueue, a rejected enqueue or a step on an empty
// ring finishes in the accept cycle: its result is valid on the next cycle.
// A step on a non-empty ring reads the head entry into the read register,
// then compares, subtracts and writes the entry back at the tail unless it
// completes; one request is in flight, and none is accepted during a step.
// A new request is accepted while the result register is empty or drains in
// that cycle. When m_tready is low the result holds and a step waits with its
// read data held in the read register.
// Reset clears head, count, quantum (to 3) and the result valid; the memory
// contents are left as they are and only written entries are ever read.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler_unit #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [rrqs_pkg::S_DATA_W-1:0] s_tdata,   // [7:0] proc_id, [23:8] burst_time
	input  logic [0:0]                   s_tuser,   // [0] req_type
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [rrqs_pkg::M_DATA_W-1:0] m_tdata,   // [7:0] served_id, [23:8] units_run,
	                                                 // [39:24] time_left
	output logic [rrqs_pkg::STAT_W-1:0]  m_tuser,   // [2:0] status
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rrqs_pkg::TIME_W-1:0]  cfg_data
);
	import rrqs_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	state_t            state_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [TIME_W-1:0] quantum_q;

	entry_t            mem [QUEUE_DEPTH];
	entry_t            rdata_q;
	logic              mem_re;
	logic              mem_we;
	entry_t            mem_wdata;

	logic              out_valid_q;
	logic [STAT_W-1:0] out_stat_q;
	logic [ID_W-1:0]   out_id_q;
	logic [TIME_W-1:0] out_units_q;
	logic [TIME_W-1:0] out_left_q;

	logic              out_free;
	logic              s_acc;
	logic              is_step;
	logic              ring_full;
	logic              ring_empty;
	logic [AW:0]       tail_sum;
	logic [AW-1:0]     tail_idx;
	logic [AW-1:0]     head_next;
	logic              finish;
	logic              completes;
	logic [TIME_W-1:0] rem_next;
	logic [ID_W-1:0]   in_id;
	logic [TIME_W-1:0] in_burst;

	assign in_id    = s_tdata[ID_W-1:0];
	assign in_burst = s_tdata[ID_W +: TIME_W];
	assign is_step  = (s_tuser[0] == REQ_STEP);

	assign out_free   = !out_valid_q || m_tready;
	assign s_tready   = (state_q == S_IDLE) && out_free;
	assign s_acc      = s_tvalid && s_tready;
	assign cfg_ready  = 1'b1;

	assign ring_full  = (count_q == CW'(QUEUE_DEPTH));
	assign ring_empty = (count_q == '0);

	// tail = (head + count) mod depth; the sum stays below twice the depth
	always_comb begin
		tail_sum = {1'b0, head_q} + (AW+1)'(count_q);
		if (tail_sum >= (AW+1)'(QUEUE_DEPTH)) begin
			tail_sum = tail_sum - (AW+1)'(QUEUE_DEPTH);
		end
		tail_idx = tail_sum[AW-1:0];
	end

	assign head_next = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);

	assign finish    = (state_q == S_READ) && out_free;
	assign completes = (rdata_q.remaining <= quantum_q);
	assign rem_next  = rdata_q.remaining - quantum_q;

	assign mem_re = s_acc && is_step && !ring_empty;

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = rdata_q;
		if (s_acc && !is_step && !ring_full) begin
			mem_we              = 1'b1;
			mem_wdata.id        = in_id;
			mem_wdata.remaining = in_burst;
		end else if (finish && !completes) begin
			mem_we              = 1'b1;
			mem_wdata.id        = rdata_q.id;
			mem_wdata.remaining = rem_next;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tail_idx] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			quantum_q <= TIME_W'(3);
		end else begin
			if (cfg_valid && cfg_ready) begin
				quantum_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_acc && !is_step && !ring_full) begin
						count_q <= count_q + CW'(1);
					end
					if (mem_re) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (finish) begin
						head_q  <= head_next;
						state_q <= S_IDLE;
						if (completes) begin
							count_q <= count_q - CW'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((s_acc && !mem_re) || finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload: load on a direct finish or at the end of a step
	always_ff @(posedge clk) begin
		if (s_acc && !is_step) begin
			out_stat_q  <= ring_full ? STAT_FULL : STAT_ENQUEUED;
			out_id_q    <= in_id;
			out_units_q <= '0;
			out_left_q  <= in_burst;
		end else if (s_acc && ring_empty) begin
			out_stat_q  <= STAT_EMPTY;
			out_id_q    <= '0;
			out_units_q <= '0;
			out_left_q  <= '0;
		end else if (finish) begin
			out_id_q <= rdata_q.id;
			if (completes) begin
				out_stat_q  <= STAT_DONE;
				out_units_q <= rdata_q.remaining;
				out_left_q  <= '0;
			end else begin
				out_stat_q  <= STAT_SLICE;
				out_units_q <= quantum_q;
				out_left_q  <= rem_next;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_stat_q;
	assign m_tdata  = {out_left_q, out_units_q, out_id_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("entry count exceeds ring depth");

	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> !ring_empty)
		else $error("step read pending on an empty ring");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && !is_step && !ring_full) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("accepted enqueue did not grow the ring");

	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && completes) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("completed process did not leave the ring");

	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (m_tvalid && (m_tuser == STAT_DONE || m_tuser == STAT_SLICE)))
		else $error("finished step gave no slice or done result");

endmodule
